// ===== design/paf_pkg.sv =====
// Package for the pitot airspeed ADC filter: widths, filter constants,
// register codes and the square-root status word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package paf_pkg;

  // Input sample and filter
  localparam int SAMPLE_BITS    = 12;
  localparam int SMOOTH_DIVISOR = 20;
  localparam int FRAC_BITS      = 8;
  localparam int AVG_W          = SAMPLE_BITS + FRAC_BITS;

  // x / D == (x * RECIP) >> RECIP_SHIFT exactly for x < 2**AVG_W
  localparam int DIV_W          = $clog2(SMOOTH_DIVISOR);
  localparam int RECIP_SHIFT    = AVG_W + DIV_W;
  localparam int RECIP_W        = AVG_W + 2;
  localparam logic [RECIP_W-1:0] SMOOTH_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + SMOOTH_DIVISOR - 1) / SMOOTH_DIVISOR);

  // Configuration registers
  localparam int VSR_W  = 16;
  localparam int PFS_W  = 16;
  localparam int CREC_W = 24;
  localparam int TOD_W  = 24;
  localparam int CFG_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [VSR_W-1:0] VSR_RESET = VSR_W'(1);
  localparam logic [TOD_W-1:0] TOD_RESET = TOD_W'(107003);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLT_SCALE_RECIP = 2'd0,
    REG_PRESS_FULLSCALE  = 2'd1,
    REG_CENTER_RECIP     = 2'd2,
    REG_TWO_OVER_DENSITY = 2'd3
  } cfg_reg_t;

  // Results
  localparam int VOLT_W  = 16;
  localparam int PRESS_W = 20;
  localparam int SPEED_W = 16;

  // Shared multiplier
  localparam int MUL_A_W = AVG_W + PFS_W;
  localparam int MUL_B_W = (RECIP_W > CREC_W) ? RECIP_W : CREC_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Pressure term: fullscale * avg(Q.8) * recip(Q0.24) >> 32
  localparam int TERM_SHIFT = FRAC_BITS + CREC_W;
  localparam int TERM_TOP   = AVG_W + PFS_W + CREC_W;
  localparam int TERM_W     = TERM_TOP - TERM_SHIFT;
  localparam int DIFF_W     = TERM_W + 1;

  // Square root
  localparam int RAD_W  = PRESS_W + TOD_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SQ_CNT_W = $clog2(ROOT_W);

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage
`default_nettype wire

// ===== design/paf_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on paf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module paf_mul
  import paf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MUL_A_W-1:0] mul_a,
  input  wire logic [MUL_B_W-1:0] mul_b,
  output logic      [MUL_P_W-1:0] prod
);

  logic [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ===== design/paf_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle (floor).
// Depends on paf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module paf_isqrt
  import paf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [RAD_W-1:0] radicand,
  output logic      [ROOT_W-1:0] root,
  output sqrt_stat_t            stat
);

  logic [RAD_W-1:0]    rad_r,  rad_nxt;
  logic [REM_W-1:0]    rem_r,  rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                busy_r, done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // bring down the next two radicand bits, try root*4+1
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    fits     = (rem_sh >= trial);
    rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[ROOT_W-2:0], fits};
    rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= SQ_CNT_W'(ROOT_W - 1);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== design/pitot_airspeed_adc_filter.sv =====
// Top level of the pitot airspeed ADC filter: sequencer, filter state,
// configuration registers and result register.
// Depends on paf_pkg, paf_mul, paf_isqrt.
//
// Usage
//   Input channel (in_valid/in_ready): one word per pressure/voltage ADC
//   sample pair. Each channel is run through an exponential average with
//   weight 1/20 (Q12.8), then battery volts, differential pressure and
//   airspeed are derived from the averages.
//   Output channel (out_valid/out_ready): one result word per input word.
//   Config port: cfg_wr_en with cfg_index/cfg_wdata writes one register;
//   write only while no word is in flight.
// Sequence
//   A word passes from acceptance to out_valid through 6 multiplies on
//   the one shared multiplier (each registered, one issue per cycle), the
//   launch of the square root, the 22 root bits of the bit-serial square
//   root (one root bit per cycle) and the load of the result register.
//   in_ready is high only while the sequencer is idle; it returns with
//   out_valid, so a new word is not accepted before the last one is done.
// Reset and stall
//   rst_n (synchronous) clears both averages, restores register defaults
//   and drops out_valid. The result register parts the two sides: a new
//   word is accepted while a result still waits; if the next result is done
//   before the old one is taken, the sequencer holds it in the root unit
//   until out_ready.
`timescale 1ns / 1ps
`default_nettype none
module pitot_airspeed_adc_filter
  import paf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input words
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [SAMPLE_BITS-1:0]   in_pressure_sample,
  input  wire logic [SAMPLE_BITS-1:0]   in_voltage_sample,
  // result words
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [VOLT_W-1:0]        out_battery_volts,
  output logic signed [PRESS_W-1:0]     out_diff_pressure_pa,
  output logic      [SPEED_W-1:0]       out_air_speed,
  // configuration
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMP,      // issue pressure smoothing multiply
    S_SMV,      // update pressure avg, issue voltage smoothing multiply
    S_PA1,      // update voltage avg, issue fullscale * pressure avg
    S_PA2,      // issue (fullscale * avg) * center recip
    S_VOLT,     // form pressure, issue voltage avg * scale
    S_SPD,      // store volts, issue pressure * 2/rho
    S_ROOT_GO,  // launch square root
    S_ROOT      // wait for root and a free result register
  } state_t;

  localparam logic [AVG_W-1:0] AVG_MAX = {{SAMPLE_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

  // config registers
  logic [VSR_W-1:0]  vsr_r;
  logic [PFS_W-1:0]  pfs_r;
  logic [CREC_W-1:0] crec_r;
  logic [TOD_W-1:0]  tod_r;

  // sequencer and datapath registers
  state_t                  state_r;
  logic [SAMPLE_BITS-1:0]  psamp_r, vsamp_r;
  logic [AVG_W-1:0]        pavg_r, vavg_r;
  logic                    neg_r;
  logic signed [PRESS_W-1:0] press_r;
  logic [VOLT_W-1:0]       volts_r;
  logic                    out_valid_r;
  logic [VOLT_W-1:0]       out_volts_r;
  logic signed [PRESS_W-1:0] out_press_r;
  logic [SPEED_W-1:0]      out_speed_r;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  // square root
  logic              sqrt_start;
  logic [ROOT_W-1:0] root;
  sqrt_stat_t        sqrt_stat;

  // filter step: d = (sample << 8) - avg, |d| goes to the multiplier
  logic [AVG_W:0]   dp, dv;
  logic [AVG_W:0]   dp_mag, dv_mag;
  logic [AVG_W-1:0] q;
  logic [AVG_W-1:0] pavg_upd, vavg_upd;

  // pressure and speed shaping
  logic [TERM_W-1:0]      term;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-PRESS_W:0]  diff_hi;
  logic signed [PRESS_W-1:0] press_sat;
  logic [AVG_W-1:0]       volt_q;
  logic [VOLT_W-1:0]      volt_sat;
  logic [SPEED_W-1:0]     speed_sat;
  logic                   load_out;

  always_comb begin
    dp = {1'b0, psamp_r, {FRAC_BITS{1'b0}}} - {1'b0, pavg_r};
    dv = {1'b0, vsamp_r, {FRAC_BITS{1'b0}}} - {1'b0, vavg_r};
    dp_mag = dp[AVG_W] ? (~dp + 1'b1) : dp;
    dv_mag = dv[AVG_W] ? (~dv + 1'b1) : dv;
    // quotient toward zero: magnitude / D, sign applied at update
    q = prod[RECIP_SHIFT +: AVG_W];
    pavg_upd = neg_r ? (pavg_r - q) : (pavg_r + q);
    vavg_upd = neg_r ? (vavg_r - q) : (vavg_r + q);
  end

  always_comb begin
    term    = prod[TERM_TOP-1:TERM_SHIFT];
    diff    = $signed({{(DIFF_W-PFS_W){1'b0}}, pfs_r}) - $signed({1'b0, term});
    diff_hi = diff[DIFF_W-1:PRESS_W-1];
    // in range when the result sign and the bits above it all agree
    if ((diff_hi == '0) || (diff_hi == '1)) begin
      press_sat = diff[PRESS_W-1:0];
    end else if (diff[DIFF_W-1]) begin
      press_sat = {1'b1, {(PRESS_W-1){1'b0}}};
    end else begin
      press_sat = {1'b0, {(PRESS_W-1){1'b1}}};
    end

    volt_q   = prod[VSR_W +: AVG_W];
    volt_sat = (volt_q > AVG_W'({VOLT_W{1'b1}})) ? '1 : volt_q[VOLT_W-1:0];

    if (press_r[PRESS_W-1]) begin
      speed_sat = '0;
    end else if (root > ROOT_W'({SPEED_W{1'b1}})) begin
      speed_sat = '1;
    end else begin
      speed_sat = root[SPEED_W-1:0];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SMP: begin
        mul_a = MUL_A_W'(dp_mag[AVG_W-1:0]);
        mul_b = MUL_B_W'(SMOOTH_RECIP);
      end
      S_SMV: begin
        mul_a = MUL_A_W'(dv_mag[AVG_W-1:0]);
        mul_b = MUL_B_W'(SMOOTH_RECIP);
      end
      S_PA1: begin
        mul_a = MUL_A_W'(pfs_r);
        mul_b = MUL_B_W'(pavg_r);
      end
      S_PA2: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(crec_r);
      end
      S_VOLT: begin
        mul_a = MUL_A_W'(vavg_r);
        mul_b = MUL_B_W'(vsr_r);
      end
      S_SPD: begin
        mul_a = MUL_A_W'($unsigned(press_r));
        mul_b = MUL_B_W'(tod_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sqrt_start = (state_r == S_ROOT_GO);
  assign load_out   = (state_r == S_ROOT) && sqrt_stat.done && (!out_valid_r || out_ready);

  paf_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  paf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (prod[RAD_W-1:0]),
    .root     (root),
    .stat     (sqrt_stat)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsr_r  <= VSR_RESET;
      pfs_r  <= '0;
      crec_r <= '0;
      tod_r  <= TOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VOLT_SCALE_RECIP: vsr_r  <= cfg_wdata[VSR_W-1:0];
        REG_PRESS_FULLSCALE:  pfs_r  <= cfg_wdata[PFS_W-1:0];
        REG_CENTER_RECIP:     crec_r <= cfg_wdata[CREC_W-1:0];
        REG_TWO_OVER_DENSITY: tod_r  <= cfg_wdata[TOD_W-1:0];
      endcase
    end
  end

  // sequencer, filter state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pavg_r      <= '0;
      vavg_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            psamp_r <= in_pressure_sample;
            vsamp_r <= in_voltage_sample;
            state_r <= S_SMP;
          end
        end
        S_SMP: begin
          neg_r   <= dp[AVG_W];
          state_r <= S_SMV;
        end
        S_SMV: begin
          pavg_r  <= pavg_upd;
          neg_r   <= dv[AVG_W];
          state_r <= S_PA1;
        end
        S_PA1: begin
          vavg_r  <= vavg_upd;
          state_r <= S_PA2;
        end
        S_PA2: begin
          state_r <= S_VOLT;
        end
        S_VOLT: begin
          press_r <= press_sat;
          state_r <= S_SPD;
        end
        S_SPD: begin
          volts_r <= volt_sat;
          state_r <= S_ROOT_GO;
        end
        S_ROOT_GO: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (load_out) begin
            out_volts_r <= volts_r;
            out_press_r <= press_r;
            out_speed_r <= speed_sat;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_battery_volts    = out_volts_r;
  assign out_diff_pressure_pa = out_press_r;
  assign out_air_speed        = out_speed_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SMP)
    else $error("accepted word did not start the sequence");

  a_neg_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_diff_pressure_pa[PRESS_W-1] |-> out_air_speed == '0)
    else $error("nonzero airspeed with negative pressure");

  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pavg_r <= AVG_MAX) && (vavg_r <= AVG_MAX))
    else $error("filter average outside sample range");

  a_root_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_stat.busy)
    else $error("square root restarted while busy");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && state_r == S_IDLE)
    else $error("finished root did not reach the result register");
`endif

endmodule
`default_nettype wire
